// ===== src/dtvcc_pkg.sv =====
// Package for the DTVCC packet assembler: codes, widths and limits.
// Used by the assembler and its checker.
`default_nettype none
package dtvcc_pkg;

   localparam int STORE_DEPTH      = 64;
   localparam int STORE_WIDTH      = 16;
   localparam int MAX_PACKET_BYTES = 128;
   localparam int DATA_BYTE_LIMIT  = 253;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [1:0] TYPE_DATA  = 2'd2;
   localparam logic [1:0] TYPE_START = 2'd3;

   localparam logic [1:0] KIND_BYTES    = 2'd0;
   localparam logic [1:0] KIND_OVERFLOW = 2'd1;
   localparam logic [1:0] KIND_SKIPPED  = 2'd2;
   localparam logic [1:0] KIND_BAD_TYPE = 2'd3;

   localparam logic CSR_DECODER_ENABLE_IDX = 1'b0;

endpackage
`default_nettype wire

// ===== src/dtvcc_if.sv =====
// Channel interfaces for caption pair requests and packet/status responses.
// Standalone; no package dependency.
`default_nettype none
interface dtvcc_req_if;
   logic       valid;
   logic       ready;
   logic       pair_valid;
   logic [1:0] pair_type;
   logic [7:0] byte_a;
   logic [7:0] byte_b;

   modport source (output valid, pair_valid, pair_type, byte_a, byte_b, input ready);
   modport sink   (input valid, pair_valid, pair_type, byte_a, byte_b, output ready);
endinterface

interface dtvcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] out_byte_a;
   logic [7:0] out_byte_b;
   logic       last_of_run;

   modport source (output valid, result_kind, out_byte_a, out_byte_b, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, out_byte_a, out_byte_b, last_of_run,
                   output ready);
endinterface
`default_nettype wire

// ===== src/dtvcc_packet_assembler.sv =====
// DTVCC packet assembler: one item per cycle while idle and not stalled by the
// response channel; a status result is registered in the cycle after its
// transaction. A packet drains from the store pair by pair (store read, then load
// of the output register when the response channel is free), taking no new item.
// Synchronous active-high reset clears control state and the enable register.
// Depends on dtvcc_pkg, dtvcc_if and dtvcc_ram.
`default_nettype none
module dtvcc_packet_assembler (
   input  wire logic                               clock,
   input  wire logic                               reset,
   dtvcc_req_if.sink                               req_chan,
   dtvcc_rsp_if.source                             rsp_chan,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [dtvcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [dtvcc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [dtvcc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                    csr_pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SEND = 2'd2;
   localparam int IDX_W = $clog2(dtvcc_pkg::STORE_DEPTH);

   logic [1:0]       state_ff, state_in;
   logic             enable_ff, enable_in;
   logic [7:0]       bytes_ff, bytes_in;
   logic             header_ff, header_in;
   logic [IDX_W:0]   pairs_ff, pairs_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_a_ff, rsp_a_in;
   logic [7:0]       rsp_b_ff, rsp_b_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                               wr_en;
   logic [IDX_W-1:0]                   wr_addr;
   logic [dtvcc_pkg::STORE_WIDTH-1:0]  wr_data;
   logic                               rd_en;
   logic [dtvcc_pkg::STORE_WIDTH-1:0]  rd_data;

   logic       rsp_free;
   logic       accept;
   logic       csr_write;
   logic [7:0] bytes_sum;
   logic       drain_last;

   dtvcc_ram #(
      .WIDTH(dtvcc_pkg::STORE_WIDTH),
      .DEPTH(dtvcc_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && rsp_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign bytes_sum      = bytes_ff + 8'd2;
   assign drain_last     = ({1'b0, cnt_ff} + (IDX_W+1)'(1)) == pairs_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dtvcc_pkg::CSR_DECODER_ENABLE_IDX)
                       ? {{(dtvcc_pkg::CSR_DATA_W-1){1'b0}}, enable_ff}
                       : '0;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.out_byte_a  = rsp_a_ff;
   assign rsp_chan.out_byte_b  = rsp_b_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      bytes_in     = bytes_ff;
      header_in    = header_ff;
      pairs_in     = pairs_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = bytes_ff[IDX_W:1];
      wr_data      = {req_chan.byte_a, req_chan.byte_b};
      rd_en        = 1'b0;

      if (csr_write && csr_paddr[2] == dtvcc_pkg::CSR_DECODER_ENABLE_IDX) begin
         enable_in = csr_pwdata[0];
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && enable_ff) begin
               case (req_chan.pair_type)
                  dtvcc_pkg::TYPE_DATA: begin
                     if (req_chan.pair_valid && header_ff) begin
                        if (bytes_ff > 8'(dtvcc_pkg::DATA_BYTE_LIMIT)) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = dtvcc_pkg::KIND_OVERFLOW;
                           rsp_a_in     = '0;
                           rsp_b_in     = '0;
                           rsp_last_in  = 1'b1;
                        end else begin
                           wr_en = 1'b1;
                           if (bytes_sum[7:1] >= pairs_ff) begin
                              bytes_in  = '0;
                              header_in = 1'b0;
                              cnt_in    = '0;
                              state_in  = S_READ;
                           end else begin
                              bytes_in = bytes_sum;
                           end
                        end
                     end
                  end
                  dtvcc_pkg::TYPE_START: begin
                     if (req_chan.pair_valid) begin
                        if (bytes_ff > 8'(dtvcc_pkg::MAX_PACKET_BYTES - 1)) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = dtvcc_pkg::KIND_OVERFLOW;
                           rsp_a_in     = '0;
                           rsp_b_in     = '0;
                           rsp_last_in  = 1'b1;
                        end else begin
                           if (header_ff) begin
                              rsp_valid_in = 1'b1;
                              rsp_kind_in  = dtvcc_pkg::KIND_SKIPPED;
                              rsp_a_in     = '0;
                              rsp_b_in     = '0;
                              rsp_last_in  = 1'b1;
                           end
                           wr_en     = 1'b1;
                           wr_addr   = '0;
                           bytes_in  = 8'd2;
                           header_in = 1'b1;
                           pairs_in  = (req_chan.byte_a[IDX_W-1:0] == '0)
                                       ? (IDX_W+1)'(dtvcc_pkg::STORE_DEPTH)
                                       : {1'b0, req_chan.byte_a[IDX_W-1:0]};
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = dtvcc_pkg::KIND_BAD_TYPE;
                     rsp_a_in     = '0;
                     rsp_b_in     = '0;
                     rsp_last_in  = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dtvcc_pkg::KIND_BYTES;
               rsp_a_in     = rd_data[15:8];
               rsp_b_in     = rd_data[7:0];
               rsp_last_in  = drain_last;
               if (drain_last) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         bytes_ff     <= '0;
         header_ff    <= 1'b0;
         pairs_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         bytes_ff     <= bytes_in;
         header_ff    <= header_in;
         pairs_ff     <= pairs_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
`default_nettype wire

// ===== src/dtvcc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module dtvcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/dtvcc_checker.sv =====
// Port-level checker for the DTVCC packet assembler, bound to the top level.
// Depends on dtvcc_pkg and the top level's ports.
`default_nettype none
module dtvcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_a,
   input wire logic [7:0] rsp_b,
   input wire logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_a) && $stable(rsp_b)
                                  && $stable(rsp_last))
      else $error("response payload changed while stalled");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dtvcc_pkg::KIND_BYTES |-> rsp_a == 8'd0 && rsp_b == 8'd0)
      else $error("status transaction carries packet bytes");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dtvcc_pkg::KIND_BYTES |-> rsp_last)
      else $error("status transaction not marked last");

endmodule

bind dtvcc_packet_assembler dtvcc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.result_kind),
   .rsp_a     (rsp_chan.out_byte_a),
   .rsp_b     (rsp_chan.out_byte_b),
   .rsp_last  (rsp_chan.last_of_run)
);
`default_nettype wire
